// ===== sv/bwms_pkg.sv =====
// Shared types and constants for the best window match search unit.
// No dependencies; used by the interfaces, the scorer and the top level.
package bwms_pkg;

    // Parameter defaults
    localparam int MAX_PATTERN_DEF = 32;
    localparam int MAX_TEXT_DEF    = 65536;

    // Field and register widths
    localparam int BASE_W    = 2;
    localparam int PAT_W     = 64;
    localparam int LEN_W     = 6;
    localparam int CNT_W     = 6;
    localparam int POS_W     = 16;
    localparam int CALC_W    = 17;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BASES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'd1;

    // Scored window handed from the scorer to the best-tracking stage
    typedef struct packed {
        logic             valid;
        logic             last;
        logic             score;
        logic [CNT_W-1:0] hits;
        logic [POS_W-1:0] offset;
    } t_stage;

    // Result payload
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] best_start;
        logic [CNT_W-1:0] best_matches;
    } t_result;

endpackage

// ===== sv/bwms_in_if.sv =====
// Request channel of the best window match search unit: one text base per request.
// Depends on bwms_pkg for field widths.
interface bwms_in_if;
    logic                        valid;
    logic                        ready;
    logic [bwms_pkg::BASE_W-1:0] base_code;
    logic                        is_last;

    modport source (output valid, output base_code, output is_last, input ready);
    modport sink   (input valid, input base_code, input is_last, output ready);
endinterface

// ===== sv/bwms_out_if.sv =====
// Result channel of the best window match search unit: one result per strand.
// Depends on bwms_pkg for field widths.
interface bwms_out_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [bwms_pkg::POS_W-1:0] best_start;
    logic [bwms_pkg::CNT_W-1:0] best_matches;

    modport source (output valid, output found, output best_start, output best_matches,
                    input ready);
    modport sink   (input valid, input found, input best_start, input best_matches,
                    output ready);
endinterface

// ===== sv/bwms_scorer.sv =====
// Window shift register, base counter and parallel match count for one base a cycle while i_take is high.
// Depends on bwms_pkg for widths and the t_stage struct.
module bwms_scorer #(
    parameter int MAX_PATTERN = bwms_pkg::MAX_PATTERN_DEF,
    parameter int MAX_TEXT    = bwms_pkg::MAX_TEXT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic [bwms_pkg::BASE_W-1:0]   i_base,
    input  logic                          i_last,
    input  logic                          i_drain,
    input  logic [bwms_pkg::PAT_W-1:0]    i_pattern,
    input  logic [bwms_pkg::LEN_W-1:0]    i_len,
    output bwms_pkg::t_stage              o_stage
);

    localparam int SEEN_W = $clog2(MAX_TEXT + 1);

    logic [bwms_pkg::BASE_W-1:0] r_window [MAX_PATTERN];
    logic [bwms_pkg::BASE_W-1:0] n_window [MAX_PATTERN];
    logic [SEEN_W-1:0]           r_seen;
    logic [SEEN_W-1:0]           n_seen;
    logic                        shift_en;
    logic                        n_score;
    logic [bwms_pkg::CNT_W-1:0]  n_hits;
    logic [bwms_pkg::POS_W-1:0]  n_offset;
    bwms_pkg::t_stage            r_stage;

    // Shift the new base in unless the strand has reached its length limit
    always_comb begin
        shift_en = (r_seen < SEEN_W'(MAX_TEXT));
        n_seen   = r_seen;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            n_window[i] = r_window[i];
        end
        if (shift_en) begin
            n_window[0] = i_base;
            for (int i = 1; i < MAX_PATTERN; i++) begin
                n_window[i] = r_window[i-1];
            end
            n_seen = r_seen + 1'b1;
        end
    end

    // Score only full windows; window age a faces pattern base len-1-a
    always_comb begin
        logic [bwms_pkg::LEN_W-1:0] idx;
        logic                       hit;
        n_score  = shift_en && (bwms_pkg::CALC_W'(n_seen) >= bwms_pkg::CALC_W'(i_len));
        n_offset = bwms_pkg::POS_W'(bwms_pkg::CALC_W'(n_seen) - bwms_pkg::CALC_W'(i_len));
        n_hits   = '0;
        for (int a = 0; a < MAX_PATTERN; a++) begin
            idx    = i_len - 1'b1 - bwms_pkg::LEN_W'(a);
            hit    = (bwms_pkg::LEN_W'(a) < i_len)
                     && (n_window[a] == i_pattern[{idx[4:0], 1'b0} +: 2]);
            n_hits = n_hits + bwms_pkg::CNT_W'(hit);
        end
    end

    // Advance the window on each request; clear the strand after its last base
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (i_take) begin
            r_seen <= i_last ? '0 : n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                r_window[i] <= n_window[i];
            end
        end
    end

    // Hold the scored window until the tracking stage takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_take) begin
            r_stage.valid <= 1'b1;
        end else if (i_drain) begin
            r_stage.valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_stage.last   <= i_last;
            r_stage.score  <= n_score;
            r_stage.hits   <= n_hits;
            r_stage.offset <= n_offset;
        end
    end

    assign o_stage = r_stage;

endmodule

// ===== sv/best_window_match_search_unit.sv =====
// Best window match search unit: top level with configuration, best tracking and result.
// Depends on bwms_pkg, bwms_in_if, bwms_out_if and bwms_scorer.
//
// Takes one text base per clock while ready is high, with no gaps between strands, and on
// the base flagged last returns one result: whether any full window of pattern_length bases
// was seen, the start of the first window with the highest count of bases equal to the
// pattern, and that count. A last base passes the stage register and then sets the result
// register. The window shift and the 32-way compare with popcount feed the stage register;
// the best-so-far compare feeds the best registers and the result register. Input ready
// drops only when a last base waits behind a result that the sink has not yet taken. Write
// configuration only while no strand is in flight. No clearing pass is needed after reset.
module best_window_match_search_unit #(
    parameter int MAX_PATTERN = bwms_pkg::MAX_PATTERN_DEF,
    parameter int MAX_TEXT    = bwms_pkg::MAX_TEXT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bwms_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bwms_pkg::PAT_W-1:0]       i_cfg_data,
    bwms_in_if.sink                          i_in,
    bwms_out_if.source                       o_out
);

    logic [bwms_pkg::PAT_W-1:0] r_pattern;
    logic [bwms_pkg::LEN_W-1:0] r_plen;
    logic [bwms_pkg::LEN_W-1:0] eff_len;

    bwms_pkg::t_stage           s1;
    logic                       in_take;
    logic                       out_free;
    logic                       s2_go;

    logic                       r_have;
    logic [bwms_pkg::CNT_W-1:0] r_bcount;
    logic [bwms_pkg::POS_W-1:0] r_boff;
    logic                       n_have;
    logic [bwms_pkg::CNT_W-1:0] n_bcount;
    logic [bwms_pkg::POS_W-1:0] n_boff;

    logic                       r_out_valid;
    bwms_pkg::t_result          r_out;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_plen    <= bwms_pkg::LEN_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bwms_pkg::REG_PATTERN_BASES:  r_pattern <= i_cfg_data;
                bwms_pkg::REG_PATTERN_LENGTH: r_plen    <= i_cfg_data[bwms_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the pattern length to 1..MAX_PATTERN
    always_comb begin
        eff_len = r_plen;
        if (r_plen == '0) begin
            eff_len = bwms_pkg::LEN_W'(1);
        end else if (r_plen > bwms_pkg::LEN_W'(MAX_PATTERN)) begin
            eff_len = bwms_pkg::LEN_W'(MAX_PATTERN);
        end
    end

    // Handshake: a last base may leave stage one only into a free result slot
    assign out_free   = !r_out_valid || o_out.ready;
    assign s2_go      = s1.valid && (!s1.last || out_free);
    assign i_in.ready = !s1.valid || s2_go;
    assign in_take    = i_in.valid && i_in.ready;

    bwms_scorer #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_TEXT    (MAX_TEXT)
    ) u_scorer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (in_take),
        .i_base    (i_in.base_code),
        .i_last    (i_in.is_last),
        .i_drain   (s2_go),
        .i_pattern (r_pattern),
        .i_len     (eff_len),
        .o_stage   (s1)
    );

    // Replace the best on the first scored window or on a strictly higher count
    always_comb begin
        n_have   = r_have;
        n_bcount = r_bcount;
        n_boff   = r_boff;
        if (s1.score && (!r_have || (s1.hits > r_bcount))) begin
            n_have   = 1'b1;
            n_bcount = s1.hits;
            n_boff   = s1.offset;
        end
    end

    // Track the best window; drop it after the strand's last base
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have   <= 1'b0;
            r_bcount <= '0;
            r_boff   <= '0;
        end else if (s2_go) begin
            if (s1.last) begin
                r_have   <= 1'b0;
                r_bcount <= '0;
                r_boff   <= '0;
            end else begin
                r_have   <= n_have;
                r_bcount <= n_bcount;
                r_boff   <= n_boff;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_go && s1.last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go && s1.last) begin
            r_out.found        <= n_have;
            r_out.best_start   <= n_have ? n_boff : '0;
            r_out.best_matches <= n_have ? n_bcount : '0;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.found        = r_out.found;
    assign o_out.best_start   = r_out.best_start;
    assign o_out.best_matches = r_out.best_matches;

`ifndef ASSERT_OFF
    // A result without a window carries zero fields
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.found) |-> (r_out.best_start == '0 && r_out.best_matches == '0))
        else $error("empty result carries nonzero fields");

    // The match count never exceeds the window depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.best_matches <= bwms_pkg::CNT_W'(MAX_PATTERN)))
        else $error("match count above pattern depth");

    // Input stalls only while stage one holds a blocked last base
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (s1.valid && s1.last && r_out_valid && !o_out.ready))
        else $error("input stalled without a blocked result");

    // A last base leaving stage one always produces a result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_go && s1.last) |=> r_out_valid)
        else $error("last base produced no result");

    // Best state is cleared after each strand's last base
    a_best_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_go && s1.last) |=> (!r_have && r_bcount == '0))
        else $error("best state not cleared after strand");
`endif

endmodule

// ===== tb/tb_best_window_match_search_unit.sv =====
// Self-checking testbench for best_window_match_search_unit: streams text strands,
// predicts the best matching window per strand and checks every result field.
// Depends on bwms_pkg, bwms_in_if, bwms_out_if and the unit's RTL.
module tb_best_window_match_search_unit;

    localparam int MAX_PATTERN    = bwms_pkg::MAX_PATTERN_DEF;
    localparam int MAX_TEXT       = bwms_pkg::MAX_TEXT_DEF;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS   = 1100;

    typedef logic [bwms_pkg::BASE_W-1:0] t_text[$];

    typedef struct {
        logic [bwms_pkg::BASE_W-1:0] base;
        logic                        last;
    } t_base_req;

    typedef enum {TXT_RANDOM, TXT_PLANTED, TXT_REPEAT} t_text_kind;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                           i_cfg_we;
    logic [bwms_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [bwms_pkg::PAT_W-1:0]     i_cfg_data;

    bwms_in_if  in_ch ();
    bwms_out_if out_ch ();

    best_window_match_search_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Register copies and per-strand search state of the prediction
    logic [bwms_pkg::PAT_W-1:0]  pat_bases = '0;
    logic [bwms_pkg::LEN_W-1:0]  pat_len   = bwms_pkg::LEN_W'(1);
    logic [bwms_pkg::BASE_W-1:0] win_bases [MAX_PATTERN];
    logic [bwms_pkg::CALC_W-1:0] bases_taken = '0;
    logic                        best_valid  = 1'b0;
    logic [bwms_pkg::CNT_W-1:0]  best_hits   = '0;
    logic [bwms_pkg::POS_W-1:0]  best_pos    = '0;

    t_base_req         base_q[$];
    bwms_pkg::t_result result_q[$];
    t_base_req         nxt;

    int  err_count   = 0;
    int  idle_cycles = 0;
    int  in_gap      = 0;
    int  out_gap     = 0;
    bit  in_idle_on  = 1'b0;
    bit  out_idle_on = 1'b0;
    logic in_fire;

    // Clock: period 2
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Pattern length as the block applies it
    function automatic int unsigned eff_len();
        int unsigned len;
        len = pat_len;
        if (len < 1) len = 1;
        if (len > MAX_PATTERN) len = MAX_PATTERN;
        return len;
    endfunction

    // Shift one accepted base into the window, score it and emit on the last base
    function automatic void score_base(input logic [bwms_pkg::BASE_W-1:0] base,
                                       input logic last);
        int unsigned       len;
        int unsigned       hits;
        bwms_pkg::t_result res;
        len = eff_len();
        if (bases_taken < MAX_TEXT) begin
            for (int i = MAX_PATTERN - 1; i > 0; i--) win_bases[i] = win_bases[i-1];
            win_bases[0] = base;
            bases_taken++;
            if (bases_taken >= len) begin
                hits = 0;
                for (int k = 0; k < len; k++)
                    if (win_bases[len-1-k] == pat_bases[2*k +: 2]) hits++;
                if (!best_valid || hits > best_hits) begin
                    best_valid = 1'b1;
                    best_hits  = bwms_pkg::CNT_W'(hits);
                    best_pos   = bwms_pkg::POS_W'(bases_taken - len);
                end
            end
        end
        if (last) begin
            res.found        = best_valid;
            res.best_start   = best_valid ? best_pos : '0;
            res.best_matches = best_valid ? best_hits : '0;
            result_q.push_back(res);
            foreach (win_bases[i]) win_bases[i] = '0;
            bases_taken = '0;
            best_valid  = 1'b0;
            best_hits   = '0;
            best_pos    = '0;
        end
    endfunction

    // Translate a letter string into base codes
    function automatic t_text letters(input string s);
        t_text txt;
        for (int i = 0; i < s.len(); i++) begin
            case (s[i])
                "A": txt.push_back(2'd0);
                "C": txt.push_back(2'd1);
                "G": txt.push_back(2'd2);
                default: txt.push_back(2'd3);
            endcase
        end
        return txt;
    endfunction

    // Build a strand of n bases of the given kind against the current pattern
    function automatic t_text make_text(input int unsigned n, input t_text_kind kind);
        t_text       txt;
        int unsigned len;
        int unsigned s;
        logic [bwms_pkg::BASE_W-1:0] fill;
        len  = eff_len();
        fill = bwms_pkg::BASE_W'($urandom_range(0, 3));
        for (int i = 0; i < n; i++)
            txt.push_back(kind == TXT_REPEAT ? fill : bwms_pkg::BASE_W'($urandom_range(0, 3)));
        if (kind == TXT_PLANTED && n >= len) begin
            repeat ($urandom_range(1, 2)) begin
                s = $urandom_range(0, n - len);
                for (int k = 0; k < len; k++) txt[s+k] = pat_bases[2*k +: 2];
                // Spoil a few positions so that counts differ between copies
                repeat ($urandom_range(0, 3))
                    txt[s + $urandom_range(0, len - 1)] =
                        bwms_pkg::BASE_W'($urandom_range(0, 3));
            end
        end
        return txt;
    endfunction

    // Queue a strand, marking its final base as last
    function automatic void push_text(input t_text txt);
        t_base_req req;
        foreach (txt[i]) begin
            req.base = txt[i];
            req.last = (i == txt.size() - 1);
            base_q.push_back(req);
        end
    endfunction

    // Write one configuration register and track it in the prediction
    task automatic write_reg(input logic [bwms_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bwms_pkg::PAT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == bwms_pkg::REG_PATTERN_BASES) pat_bases = data;
        else pat_len = data[bwms_pkg::LEN_W-1:0];
    endtask

    task automatic set_pattern(input logic [bwms_pkg::PAT_W-1:0] bases,
                               input logic [bwms_pkg::LEN_W-1:0] len);
        write_reg(bwms_pkg::REG_PATTERN_BASES, bases);
        write_reg(bwms_pkg::REG_PATTERN_LENGTH, bwms_pkg::PAT_W'(len));
    endtask

    // Wait until every queued request is taken and every result has come back
    task automatic drain();
        do @(posedge i_clk);
        while (base_q.size() != 0 || in_ch.valid || result_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Request driver: hold until taken, insert idle bursts, then send the next base
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_fire) begin
            // hold the pending request
        end else if (in_gap != 0) begin
            in_gap      <= in_gap - 1;
            in_ch.valid <= 1'b0;
        end else if (in_idle_on && base_q.size() != 0 && $urandom_range(0, 7) == 0) begin
            in_gap      <= $urandom_range(0, 11);
            in_ch.valid <= 1'b0;
        end else if (base_q.size() != 0) begin
            nxt = base_q.pop_front();
            in_ch.valid     <= 1'b1;
            in_ch.base_code <= nxt.base;
            in_ch.is_last   <= nxt.last;
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // Result sink: stall in random bursts
    always @(negedge i_clk) begin
        if (out_gap != 0) begin
            out_gap      <= out_gap - 1;
            out_ch.ready <= 1'b0;
        end else if (out_idle_on && $urandom_range(0, 7) == 0) begin
            out_gap      <= $urandom_range(0, 11);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Monitor: predict on each taken request, check each taken result, watch for a hang
    always @(posedge i_clk) begin
        bwms_pkg::t_result exp_res;
        if (!i_rst_n) begin
            in_fire     <= 1'b0;
            idle_cycles <= 0;
        end else begin
            in_fire <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready) score_base(in_ch.base_code, in_ch.is_last);
            if (out_ch.valid && out_ch.ready) begin
                if (result_q.size() == 0) begin
                    $error("unexpected result: found %0d best_start %0d best_matches %0d",
                           out_ch.found, out_ch.best_start, out_ch.best_matches);
                    err_count++;
                end else begin
                    exp_res = result_q.pop_front();
                    if (out_ch.found !== exp_res.found) begin
                        $error("found: expected %0d, got %0d", exp_res.found, out_ch.found);
                        err_count++;
                    end
                    if (out_ch.best_start !== exp_res.best_start) begin
                        $error("best_start: expected %0d, got %0d",
                               exp_res.best_start, out_ch.best_start);
                        err_count++;
                    end
                    if (out_ch.best_matches !== exp_res.best_matches) begin
                        $error("best_matches: expected %0d, got %0d",
                               exp_res.best_matches, out_ch.best_matches);
                        err_count++;
                    end
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        int unsigned total;
        int unsigned phase_goal;
        int unsigned n;
        int unsigned len;
        int unsigned phase;
        logic [bwms_pkg::LEN_W-1:0] len_val;
        logic [bwms_pkg::PAT_W-1:0] bases_val;
        t_text_kind kind;

        foreach (win_bases[i]) win_bases[i] = '0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        in_ch.valid     = 1'b0;
        in_ch.base_code = '0;
        in_ch.is_last   = 1'b0;
        out_ch.ready    = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset configuration, single-base pattern of A
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        push_text(letters("T"));
        push_text(letters("GA"));
        drain();

        // Pattern ACGT: short strand, exact hit, later tie kept at the first window
        set_pattern(bwms_pkg::PAT_W'(8'hE4), bwms_pkg::LEN_W'(4));
        push_text(letters("ACG"));
        push_text(letters("ACGT"));
        push_text(letters("TTACGTACGT"));
        drain();

        // Length zero acts as one, length above the maximum acts as the maximum
        set_pattern('1, '0);
        push_text(letters("AT"));
        drain();
        set_pattern(bwms_pkg::PAT_W'(64'h0123_4567_89AB_CDEF), bwms_pkg::LEN_W'(63));
        push_text(letters("A"));
        drain();

        // Random phases with a fresh configuration each
        total = 0;
        phase = 0;
        while (total < RANDOM_ITEMS) begin
            case (phase)
                0: len_val = bwms_pkg::LEN_W'(1);
                1: len_val = bwms_pkg::LEN_W'(32);
                2: len_val = '0;
                3: len_val = '1;
                default: begin
                    case ($urandom_range(0, 5))
                        0: len_val = bwms_pkg::LEN_W'($urandom_range(33, 62));
                        1: len_val = bwms_pkg::LEN_W'(32);
                        default: len_val = bwms_pkg::LEN_W'($urandom_range(2, 12));
                    endcase
                end
            endcase
            case ($urandom_range(0, 5))
                0: bases_val = '0;
                1: bases_val = '1;
                default: bases_val = {$urandom, $urandom};
            endcase
            set_pattern(bases_val, len_val);
            in_idle_on  = ($urandom_range(0, 3) != 0);
            out_idle_on = ($urandom_range(0, 3) != 0);
            len = eff_len();
            phase_goal = total + $urandom_range(60, 120);
            while (total < phase_goal) begin
                if ($urandom_range(0, 5) == 0) n = $urandom_range(1, len);
                else n = $urandom_range(len, 2 * len + 8);
                case ($urandom_range(0, 3))
                    0: kind = TXT_RANDOM;
                    3: kind = TXT_REPEAT;
                    default: kind = TXT_PLANTED;
                endcase
                push_text(make_text(n, kind));
                total += n;
            end
            drain();
            phase++;
        end

        // Closing part without idling: back-to-back strands, full match after a miss
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        set_pattern('0, bwms_pkg::LEN_W'(8));
        push_text(letters("TTTTTTTTTTAAAAAAAA"));
        push_text(letters("AAAAAAAA"));
        push_text(letters("TA"));
        push_text(make_text(40, TXT_PLANTED));
        drain();

        repeat (8) @(posedge i_clk);
        if (err_count == 0 && result_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== best_window_match_search_unit.f =====
sv/bwms_pkg.sv
sv/bwms_in_if.sv
sv/bwms_out_if.sv
sv/bwms_scorer.sv
sv/best_window_match_search_unit.sv
tb/tb_best_window_match_search_unit.sv
